[rtl/ntfs_run_list_vcn_to_lcn_top_assert.svh]
// ============================================================================
// Assertion macros for the run-list decoder checker
// Each macro expects clk and arst_n to be visible where it is used.
// ============================================================================
`ifndef NTFS_RUN_LIST_VCN_TO_LCN_TOP_ASSERT_SVH
`define NTFS_RUN_LIST_VCN_TO_LCN_TOP_ASSERT_SVH

// Same-cycle implication
`define NRL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define NRL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/nrl_pkg.sv]
// ============================================================================
// nrl_pkg
// Shared types and codes for the data-run list VCN to LCN decoder.
// ============================================================================
package nrl_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_COUNT  = 2'd2,
		PH_OFFSET = 2'd3
	} phase_t;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_BADSIZE  = 2'd2;

	localparam logic [3:0] MAX_SIZE = 4'd8;

endpackage

[rtl/nrl_if.sv]
// ============================================================================
// nrl_in_if / nrl_out_if
// Valid/ready channels for run-list bytes and lookup results.
// ============================================================================
interface nrl_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  run_byte;
	logic        first_byte;
	logic        last_byte;
	logic [63:0] target_vcn;

	modport source (output valid, run_byte, first_byte, last_byte, target_vcn, input ready);
	modport sink   (input valid, run_byte, first_byte, last_byte, target_vcn, output ready);
endinterface

interface nrl_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] lcn;
	logic [1:0]  status;

	modport source (output valid, lcn, status, input ready);
	modport sink   (input valid, lcn, status, output ready);
endinterface

[rtl/nrl_in_stage.sv]
// ============================================================================
// nrl_in_stage
// Input register: holds one request for the decode stage.
// ============================================================================
module nrl_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	nrl_in_if.sink       up,
	nrl_in_if.source     dn
);

	logic        valid_s1;
	logic [7:0]  run_byte_s1;
	logic        first_byte_s1;
	logic        last_byte_s1;
	logic [63:0] target_vcn_s1;

	// advance whenever the stage is empty or its request moves on
	assign up.ready = !valid_s1 || dn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up.ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.ready && up.valid) begin
			run_byte_s1   <= up.run_byte;
			first_byte_s1 <= up.first_byte;
			last_byte_s1  <= up.last_byte;
			target_vcn_s1 <= up.target_vcn;
		end
	end

	assign dn.valid      = valid_s1;
	assign dn.run_byte   = run_byte_s1;
	assign dn.first_byte = first_byte_s1;
	assign dn.last_byte  = last_byte_s1;
	assign dn.target_vcn = target_vcn_s1;

endmodule

[rtl/nrl_core.sv]
// ============================================================================
// nrl_core
// Run-list parser state and per-byte decode; emits on hit, end or bad size.
// ============================================================================
module nrl_core
	import nrl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	nrl_in_if.sink       req,
	nrl_out_if.source    res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  bytes_left_q, bytes_left_d;
	logic [2:0]  byte_pos_q, byte_pos_d;
	logic [3:0]  offset_size_q, offset_size_d;
	logic [63:0] count_q, count_d;
	logic [63:0] offset_q, offset_d;
	logic [63:0] running_q, running_d;
	logic [63:0] remaining_q, remaining_d;
	logic [63:0] base_q, base_d;

	phase_t      cur_phase;
	logic [7:0]  b;
	logic [3:0]  cnt_size;
	logic [3:0]  off_size;
	logic [63:0] ins;
	logic [6:0]  fill_sh;
	logic [63:0] fill_mask;
	logic [63:0] sext_off;
	logic [63:0] fin_off;
	logic [63:0] fin_count;
	logic [63:0] fin_running;
	logic [63:0] hit_lcn;
	logic        hit;
	logic [3:0]  left_dec;
	logic        emit;
	logic [63:0] res_lcn;
	logic [1:0]  res_status;
	logic        fire;

	assign b         = req.run_byte;
	assign cnt_size  = b[3:0];
	assign off_size  = b[7:4];
	assign cur_phase = req.first_byte ? PH_HEADER : phase_q;
	assign left_dec  = bytes_left_q - 4'd1;

	// place the byte at its little-endian position
	assign ins       = 64'(b) << {byte_pos_q, 3'b000};
	// sign fill for every byte above the top offset byte
	assign fill_sh   = {1'b0, byte_pos_q, 3'b000} + 7'd8;
	assign fill_mask = {64{1'b1}} << fill_sh;
	assign sext_off  = offset_q | ins | (b[7] ? fill_mask : 64'd0);

	assign fin_off     = (cur_phase == PH_OFFSET) ? sext_off : 64'd0;
	assign fin_count   = (cur_phase == PH_COUNT) ? (count_q | ins) : count_q;
	assign hit         = remaining_q < fin_count;
	assign fin_running = running_q + fin_off;
	// base_q already holds running + remaining for this run
	assign hit_lcn     = base_q + fin_off;

	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		byte_pos_d    = byte_pos_q;
		offset_size_d = offset_size_q;
		count_d       = count_q;
		offset_d      = offset_q;
		running_d     = running_q;
		remaining_d   = remaining_q;
		base_d        = base_q;
		emit          = 1'b0;
		res_lcn       = 64'd0;
		res_status    = ST_NOTFOUND;

		if (req.first_byte) begin
			remaining_d = req.target_vcn;
			running_d   = 64'd0;
		end

		unique case (cur_phase)
			PH_IDLE: begin
			end
			PH_HEADER: begin
				if (b == 8'd0) begin
					emit       = 1'b1;
					res_status = ST_NOTFOUND;
				end else if (cnt_size > MAX_SIZE || off_size > MAX_SIZE) begin
					emit       = 1'b1;
					res_status = ST_BADSIZE;
				end else begin
					count_d       = 64'd0;
					offset_d      = 64'd0;
					byte_pos_d    = 3'd0;
					offset_size_d = off_size;
					base_d        = req.first_byte ? req.target_vcn
						: (running_q + remaining_q);
					if (cnt_size != 4'd0) begin
						bytes_left_d = cnt_size;
						phase_d      = PH_COUNT;
					end else begin
						bytes_left_d = off_size;
						phase_d      = PH_OFFSET;
					end
				end
			end
			PH_COUNT: begin
				count_d      = count_q | ins;
				byte_pos_d   = byte_pos_q + 3'd1;
				bytes_left_d = left_dec;
				if (left_dec == 4'd0) begin
					if (offset_size_q != 4'd0) begin
						bytes_left_d = offset_size_q;
						byte_pos_d   = 3'd0;
						phase_d      = PH_OFFSET;
					end else begin
						running_d = fin_running;
						if (hit) begin
							emit       = 1'b1;
							res_lcn    = hit_lcn;
							res_status = ST_FOUND;
						end else begin
							remaining_d = remaining_q - fin_count;
							phase_d     = PH_HEADER;
						end
					end
				end
			end
			PH_OFFSET: begin
				offset_d     = offset_q | ins;
				byte_pos_d   = byte_pos_q + 3'd1;
				bytes_left_d = left_dec;
				if (left_dec == 4'd0) begin
					running_d = fin_running;
					if (hit) begin
						emit       = 1'b1;
						res_lcn    = hit_lcn;
						res_status = ST_FOUND;
					end else begin
						remaining_d = remaining_q - fin_count;
						phase_d     = PH_HEADER;
					end
				end
			end
			default: begin
			end
		endcase

		// list ends without a hit
		if (cur_phase != PH_IDLE && !emit && req.last_byte) begin
			emit       = 1'b1;
			res_lcn    = 64'd0;
			res_status = ST_NOTFOUND;
		end

		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	assign fire       = req.valid && res.ready;
	assign req.ready  = res.ready;
	assign res.valid  = req.valid && emit;
	assign res.lcn    = res_lcn;
	assign res.status = res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bytes_left_q  <= 4'd0;
			byte_pos_q    <= 3'd0;
			offset_size_q <= 4'd0;
			count_q       <= 64'd0;
			offset_q      <= 64'd0;
			running_q     <= 64'd0;
			remaining_q   <= 64'd0;
			base_q        <= 64'd0;
		end else if (fire) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			byte_pos_q    <= byte_pos_d;
			offset_size_q <= offset_size_d;
			count_q       <= count_d;
			offset_q      <= offset_d;
			running_q     <= running_d;
			remaining_q   <= remaining_d;
			base_q        <= base_d;
		end
	end

endmodule

[rtl/nrl_out_stage.sv]
// ============================================================================
// nrl_out_stage
// Result register: holds one result until the consumer takes it.
// ============================================================================
module nrl_out_stage (
	input  logic         clk,
	input  logic         arst_n,
	nrl_out_if.sink      up,
	nrl_out_if.source    dn
);

	logic        valid_q;
	logic [63:0] lcn_q;
	logic [1:0]  status_q;

	assign up.ready = !valid_q || dn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up.ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.ready && up.valid) begin
			lcn_q    <= up.lcn;
			status_q <= up.status;
		end
	end

	assign dn.valid  = valid_q;
	assign dn.lcn    = lcn_q;
	assign dn.status = status_q;

endmodule

[rtl/ntfs_run_list_vcn_to_lcn_top.sv]
// ============================================================================
// ntfs_run_list_vcn_to_lcn_top: data-run list VCN to LCN lookup, one byte a cycle
// Path: the input register takes each byte, the core decodes it, and the result register
// loads the result of the byte that ends the lookup.
// Throughput: 1 byte per cycle; the input stalls only while a result waits unaccepted.
// Reset: arst_n clears both stage valids and returns the parser to idle.
// ============================================================================
module ntfs_run_list_vcn_to_lcn_top (
	input  logic         clk,
	input  logic         arst_n,
	nrl_in_if.sink       bytes,
	nrl_out_if.source    result
);

	// Internal channels:
	//   bytes  -> input register -> s1 channel -> decode core
	//   decode core -> res channel -> result register -> result
	nrl_in_if  s1_ch ();
	nrl_out_if res_ch ();

	// Register each accepted request before decode.
	nrl_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (bytes),
		.dn     (s1_ch)
	);

	// Decode one byte per cycle unless stalled: header, count bytes, offset bytes.
	// A run ends with one 64-bit add and one 64-bit compare; the running
	// base (LCN plus remaining VCN) is precomputed on the header byte so
	// the hit LCN needs only one more add.
	nrl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (s1_ch),
		.res    (res_ch)
	);

	// Register results; hold the decoder and the input while a result waits.
	nrl_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (res_ch),
		.dn     (result)
	);

endmodule

[rtl/nrl_checker.sv]
// ============================================================================
// nrl_checker
// Port-level checks on the run-list decoder, bound to the top level.
// ============================================================================
`include "ntfs_run_list_vcn_to_lcn_top_assert.svh"

module nrl_checker
	import nrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_run_byte,
	input  logic        in_first_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_lcn,
	input  logic [1:0]  out_status
);

	`NRL_ASSERT_IMP(a_lcn_zero_unless_found, out_valid && out_status != ST_FOUND, out_lcn == 64'd0, "lcn not zero on a miss")
	`NRL_ASSERT_IMP(a_ready_when_out_empty, !out_valid, in_ready, "input stalled with empty output")
	`NRL_ASSERT_NXT(a_zero_header_ends, in_valid && in_ready && in_first_byte && in_run_byte == 8'd0 ##1 (!out_valid || out_ready), out_valid && out_status == ST_NOTFOUND, "zero header gave no not-found result")
	`NRL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lcn) && $stable(out_status), "stalled result changed")

endmodule

bind ntfs_run_list_vcn_to_lcn_top nrl_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (bytes.valid),
	.in_ready      (bytes.ready),
	.in_run_byte   (bytes.run_byte),
	.in_first_byte (bytes.first_byte),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_lcn       (result.lcn),
	.out_status    (result.status)
);
